[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also looks at the reset cycles.
`define ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/dqt_pkg.sv]
// Shared types, constants and helper functions of the DQT payload extractor.
`timescale 1ns / 1ps

package dqt_pkg;

  localparam int BYTE_W          = 8;
  localparam int MODE_W          = 2;
  localparam int SEL_W           = 3;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 3;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BITS_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_SELECT = 1'd1;

  // Extraction modes.
  localparam logic [MODE_W-1:0] MODE_ONE_BIT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TWO_BITS  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FOUR_BITS = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BYTE      = 2'd3;

  // Marker bytes and the table header spacing.
  localparam logic [BYTE_W-1:0] MARKER_PREFIX = 8'hFF;
  localparam logic [BYTE_W-1:0] MARKER_DQT    = 8'hDB;
  localparam logic [6:0]        HEADER_GAP    = 7'd64;

  // One payload byte handed from the parser to the bit packer.
  typedef struct packed {
    logic              push;
    logic [BYTE_W-1:0] data;
  } dqt_push_t;

  // Bit position where the first group of a new character lands.
  function automatic logic [2:0] start_shift(input logic [MODE_W-1:0] mode);
    logic [2:0] s;
    case (mode)
      MODE_ONE_BIT:   s = 3'd7;
      MODE_TWO_BITS:  s = 3'd6;
      MODE_FOUR_BITS: s = 3'd4;
      default:        s = 3'd0;
    endcase
    return s;
  endfunction

  // Number of bits taken from each payload byte.
  function automatic logic [3:0] group_width(input logic [MODE_W-1:0] mode);
    logic [3:0] w;
    case (mode)
      MODE_ONE_BIT:   w = 4'd1;
      MODE_TWO_BITS:  w = 4'd2;
      MODE_FOUR_BITS: w = 4'd4;
      default:        w = 4'd8;
    endcase
    return w;
  endfunction

endpackage

[rtl/core/dqt_queue.sv]
// Short FIFO of payload bytes between the segment parser and the bit packer.
`timescale 1ns / 1ps

module dqt_queue #(
  parameter int DEPTH = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dqt_pkg::dqt_push_t        wr,
  input  logic                      rd_en,
  output logic                      full,
  output logic                      rd_valid,
  output logic [dqt_pkg::BYTE_W-1:0] rd_data
);
  import dqt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [BYTE_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_wr, do_rd;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  assign do_wr = wr.push && !full;
  assign do_rd = rd_en && rd_valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset; only entries counted in the fill count are read.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr.data;
    end
  end

endmodule

[rtl/core/dqt_front.sv]
// Segment parser: finds the DQT marker, reads the length and picks payload bytes.
`timescale 1ns / 1ps

module dqt_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [dqt_pkg::BYTE_W-1:0] in_byte,
  output dqt_pkg::dqt_push_t         push
);
  import dqt_pkg::*;

  localparam logic [2:0] PH_SEARCH  = 3'd0;
  localparam logic [2:0] PH_GOT_FF  = 3'd1;
  localparam logic [2:0] PH_LEN_HI  = 3'd2;
  localparam logic [2:0] PH_LEN_LO  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_IDLE    = 3'd5;

  logic [2:0]        phase_r, phase_nxt;
  logic [BYTE_W-1:0] len_hi_r, len_hi_nxt;
  logic [15:0]       limit_r, limit_nxt;
  logic [15:0]       count_r, count_nxt;
  logic [6:0]        offset_r, offset_nxt;
  logic [15:0]       seg_len;
  logic [15:0]       count_inc;
  logic              take;

  assign seg_len   = {len_hi_r, in_byte};
  assign count_inc = count_r + 16'd1;

  // Phase walk over one transfer.
  always_comb begin
    phase_nxt  = phase_r;
    len_hi_nxt = len_hi_r;
    limit_nxt  = limit_r;
    count_nxt  = count_r;
    offset_nxt = offset_r;
    take       = 1'b0;
    if (accept) begin
      unique case (phase_r)
        PH_SEARCH: begin
          if (in_byte == MARKER_PREFIX) begin
            phase_nxt = PH_GOT_FF;
          end
        end
        PH_GOT_FF: begin
          // Fill bytes keep the prefix armed.
          if (in_byte == MARKER_DQT) begin
            phase_nxt = PH_LEN_HI;
          end else if (in_byte != MARKER_PREFIX) begin
            phase_nxt = PH_SEARCH;
          end
        end
        PH_LEN_HI: begin
          len_hi_nxt = in_byte;
          phase_nxt  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          limit_nxt  = seg_len - 16'd2;
          count_nxt  = '0;
          offset_nxt = HEADER_GAP;
          phase_nxt  = (seg_len <= 16'd2) ? PH_IDLE : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          // The first byte of each table is its header and is skipped.
          if (offset_r >= HEADER_GAP) begin
            offset_nxt = '0;
          end else begin
            take       = 1'b1;
            offset_nxt = offset_r + 7'd1;
          end
          count_nxt = count_inc;
          if (count_inc >= limit_r) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  assign push.push = take;
  assign push.data = in_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEARCH;
      len_hi_r <= '0;
      limit_r  <= '0;
      count_r  <= '0;
      offset_r <= HEADER_GAP;
    end else begin
      phase_r  <= phase_nxt;
      len_hi_r <= len_hi_nxt;
      limit_r  <= limit_nxt;
      count_r  <= count_nxt;
      offset_r <= offset_nxt;
    end
  end

endmodule

[rtl/core/dqt_packer.sv]
// Bit packer: holds the configuration, extracts bit groups and builds characters.
`timescale 1ns / 1ps

module dqt_packer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dqt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dqt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           q_valid,
  input  logic [dqt_pkg::BYTE_W-1:0]     q_data,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [dqt_pkg::BYTE_W-1:0]     out_char
);
  import dqt_pkg::*;

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [SEL_W-1:0]  sel_r, sel_nxt;
  logic [BYTE_W-1:0] accum_r, accum_nxt;
  logic [2:0]        shift_r, shift_nxt;
  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] char_r, char_nxt;
  logic [BYTE_W-1:0] group;
  logic [BYTE_W-1:0] merged;
  logic [3:0]        width;
  logic              done;

  // Group selected by the current mode.
  always_comb begin
    unique case (mode_r)
      MODE_ONE_BIT:   group = {7'd0, q_data[sel_r]};
      MODE_TWO_BITS:  group = q_data & 8'h03;
      MODE_FOUR_BITS: group = q_data & 8'h0F;
      default:        group = q_data;
    endcase
  end

  assign width  = group_width(mode_r);
  assign merged = accum_r | (group << shift_r);
  assign done   = ({1'b0, shift_r} < width);

  // Take the next byte when the output register is free or being drained.
  assign q_pop = q_valid && (!valid_r || !out_stall);

  always_comb begin
    mode_nxt  = mode_r;
    sel_nxt   = sel_r;
    accum_nxt = accum_r;
    shift_nxt = shift_r;
    valid_nxt = valid_r && out_stall;
    char_nxt  = char_r;
    if (q_pop) begin
      if (done) begin
        char_nxt  = merged;
        valid_nxt = 1'b1;
        accum_nxt = '0;
        shift_nxt = start_shift(mode_r);
      end else begin
        accum_nxt = merged;
        shift_nxt = shift_r - width[2:0];
      end
    end
    // Register writes are to arrive only while the block is idle; the block does not enforce it.
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_BITS_MODE: begin
          mode_nxt  = cfg_wdata[MODE_W-1:0];
          accum_nxt = '0;
          shift_nxt = start_shift(cfg_wdata[MODE_W-1:0]);
        end
        CFG_BIT_SELECT: begin
          sel_nxt = cfg_wdata[SEL_W-1:0];
        end
        default: begin
          sel_nxt = sel_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_ONE_BIT;
      sel_r   <= '0;
      accum_r <= '0;
      shift_r <= 3'd7;
      valid_r <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      sel_r   <= sel_nxt;
      accum_r <= accum_nxt;
      shift_r <= shift_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

  assign out_valid = valid_r;
  assign out_char  = char_r;

endmodule

[rtl/core/dqt_lsb_payload_extractor.sv]
// Top level of the DQT payload extractor: parser, byte queue and bit packer.
//
//   Channel   Direction  Ports                          Transfer when
//   input     in         in_valid, in_stall, in_byte    in_valid && !in_stall
//   result    out        out_valid, out_stall, out_char out_valid && !out_stall
//   config    in         cfg_we, cfg_index, cfg_wdata   cfg_we
//
// One byte is taken per cycle; in_stall rises only when the byte queue is full.
// A character appears on out_char after the byte that completes it has passed
// the queue register between parser and packer and the packer's output register.
// rst_n is synchronous and active low; no clearing pass follows it.
// A stall on the result side fills the queue of QUEUE_DEPTH bytes, then
// holds the input side.
`timescale 1ns / 1ps

module dqt_lsb_payload_extractor #(
  parameter int QUEUE_DEPTH = dqt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [dqt_pkg::BYTE_W-1:0]     in_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [dqt_pkg::BYTE_W-1:0]     out_char,
  input  logic                           cfg_we,
  input  logic [dqt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dqt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dqt_pkg::*;

  dqt_push_t         push;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic [BYTE_W-1:0] q_data;
  logic              in_xfer;

  assign in_stall = q_full;
  assign in_xfer  = in_valid && !q_full;

  dqt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_xfer),
    .in_byte (in_byte),
    .push    (push)
  );

  dqt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (push),
    .rd_en    (q_pop),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  dqt_packer u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char)
  );

endmodule

[rtl/core/dqt_checker.sv]
// Port-level checks of the DQT payload extractor and their bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dqt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [dqt_pkg::BYTE_W-1:0] out_char
);

  // A stalled character stays put until its transfer.
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_char), "stalled result dropped or changed")

  // Reset empties the queue, so the input side is open right after it.
  `ASSERT_RST(a_rst_open, clk, !rst_n |=> !in_stall, "input stalled after reset")

  // Reset clears the output register.
  `ASSERT_RST(a_rst_out, clk, !rst_n |=> !out_valid, "result valid after reset")

  // With no byte transferred since reset, no character can come out.
  `ASSERT_RST(a_no_spurious, clk, !rst_n ##1 !(in_valid && !in_stall) |=> !out_valid, "result without input")

endmodule

bind dqt_lsb_payload_extractor dqt_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_char  (out_char)
);

[bench/dqt_char_checker.sv]
// Checker for the DQT payload extractor: predicts hidden characters and compares transfers.
`timescale 1ns / 1ps

module dqt_char_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [dqt_pkg::BYTE_W-1:0]     in_byte,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [dqt_pkg::BYTE_W-1:0]     out_char,
  input  logic                           cfg_we,
  input  logic [dqt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dqt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             chars_in_flight,
  output int                             mismatch_count
);
  import dqt_pkg::*;

  // Parser position within the file.
  localparam logic [2:0] SEEK_PREFIX  = 3'd0;
  localparam logic [2:0] SEEN_PREFIX  = 3'd1;
  localparam logic [2:0] LEN_HIGH     = 3'd2;
  localparam logic [2:0] LEN_LOW      = 3'd3;
  localparam logic [2:0] WALK_PAYLOAD = 3'd4;
  localparam logic [2:0] SEGMENT_DONE = 3'd5;

  // Predicted copy of the registers and the parser and packer state.
  logic [MODE_W-1:0] cur_mode;
  logic [SEL_W-1:0]  cur_sel;
  logic [2:0]        phase;
  logic [15:0]       seg_len;
  logic [15:0]       walked;
  logic [6:0]        table_pos;
  logic [7:0]        char_acc;
  logic [2:0]        shift_pos;
  logic [7:0]        hidden_chars[$];

  // Bit position where the first group of a character lands.
  function automatic logic [2:0] first_shift(input logic [MODE_W-1:0] m);
    case (m)
      MODE_ONE_BIT:   return 3'd7;
      MODE_TWO_BITS:  return 3'd6;
      MODE_FOUR_BITS: return 3'd4;
      default:        return 3'd0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: char check: %s, got %02h, expected %02h", $time, what, got, want);
    mismatch_count = mismatch_count + 1;
  endtask

  // Takes the selected bits of one payload byte into the character being built.
  task automatic pack_bits(input logic [7:0] b);
    logic [7:0] group;
    logic [3:0] width;
    case (cur_mode)
      MODE_ONE_BIT: begin
        group = {7'd0, b[cur_sel]};
        width = 4'd1;
      end
      MODE_TWO_BITS: begin
        group = b & 8'h03;
        width = 4'd2;
      end
      MODE_FOUR_BITS: begin
        group = b & 8'h0F;
        width = 4'd4;
      end
      default: begin
        group = b;
        width = 4'd8;
      end
    endcase
    char_acc = char_acc | (group << shift_pos);
    if ({1'b0, shift_pos} < width) begin
      hidden_chars.push_back(char_acc);
      char_acc  = 8'd0;
      shift_pos = first_shift(cur_mode);
    end else begin
      shift_pos = shift_pos - width[2:0];
    end
  endtask

  // Advances the parser by one file byte.
  task automatic parse_byte(input logic [7:0] b);
    case (phase)
      SEEK_PREFIX: begin
        if (b == MARKER_PREFIX) phase = SEEN_PREFIX;
      end
      SEEN_PREFIX: begin
        // Fill bytes keep the prefix armed; anything else restarts the hunt.
        if (b == MARKER_DQT) phase = LEN_HIGH;
        else if (b != MARKER_PREFIX) phase = SEEK_PREFIX;
      end
      LEN_HIGH: begin
        seg_len = {b, 8'd0};
        phase   = LEN_LOW;
      end
      LEN_LOW: begin
        seg_len   = {seg_len[15:8], b};
        walked    = 16'd0;
        table_pos = HEADER_GAP;
        phase     = (seg_len <= 16'd2) ? SEGMENT_DONE : WALK_PAYLOAD;
      end
      WALK_PAYLOAD: begin
        // The first byte of every group of 65 is a table header.
        if (table_pos >= HEADER_GAP) begin
          table_pos = 7'd0;
        end else begin
          pack_bits(b);
          table_pos = table_pos + 7'd1;
        end
        walked = walked + 16'd1;
        if (walked >= seg_len - 16'd2) phase = SEGMENT_DONE;
      end
      default: ;
    endcase
  endtask

  task automatic check_char(input logic [7:0] got);
    logic [7:0] want;
    if (hidden_chars.size() == 0) begin
      report_mismatch("character with none expected", got, 8'h00);
    end else begin
      want = hidden_chars.pop_front();
      if (got !== want) report_mismatch("wrong character", got, want);
    end
  endtask

  // Result transfers are checked before the input transfer of the same edge,
  // since a character can only come from an earlier byte.
  always @(posedge clk) begin
    if (!rst_n) begin
      cur_mode       = MODE_ONE_BIT;
      cur_sel        = '0;
      phase          = SEEK_PREFIX;
      seg_len        = 16'd0;
      walked         = 16'd0;
      table_pos      = HEADER_GAP;
      char_acc       = 8'd0;
      shift_pos      = 3'd7;
      mismatch_count = 0;
      hidden_chars.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_BITS_MODE) begin
          cur_mode  = cfg_wdata[MODE_W-1:0];
          char_acc  = 8'd0;
          shift_pos = first_shift(cur_mode);
        end else if (cfg_index == CFG_BIT_SELECT) begin
          cur_sel = cfg_wdata[SEL_W-1:0];
        end
      end
      if (out_valid && !out_stall) check_char(out_char);
      if (in_valid && !in_stall) parse_byte(in_byte);
    end
    chars_in_flight <= hidden_chars.size();
  end

endmodule

[bench/dqt_lsb_payload_extractor_tb.sv]
// Testbench top for the DQT payload extractor: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module dqt_lsb_payload_extractor_tb;
  import dqt_pkg::*;

  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_COUNT    = 8;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic [BYTE_W-1:0]     in_byte   = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic [BYTE_W-1:0]     out_char;
  int                    chars_in_flight;
  int                    mismatch_count;

  // Idle and stall rates in percent; quiet_cycles counts cycles without a transfer.
  int idle_pct     = 0;
  int stall_pct    = 0;
  int quiet_cycles = 0;

  dqt_lsb_payload_extractor dut (.*);

  dqt_char_checker char_check (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver side: random stalls at the current rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offers one byte after random idle cycles and returns at its transfer edge.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops sending and waits until every predicted character has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_in_flight != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes bit_select, and bits_mode first when asked.
  task automatic configure(input logic write_mode, input logic [MODE_W-1:0] m,
                           input logic [SEL_W-1:0] sel);
    if (write_mode) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_BITS_MODE;
      cfg_wdata <= CFG_DATA_W'(m);
      @(posedge clk);
    end
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BIT_SELECT;
    cfg_wdata <= CFG_DATA_W'(sel);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Payload content, with marker bytes mixed in more often than chance.
  function automatic logic [7:0] payload_byte();
    case ($urandom_range(9))
      0:       return MARKER_PREFIX;
      1:       return MARKER_DQT;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int                payload_len;
    int                chunk;
    int                left;
    int                n;
    logic [15:0]       seg_len;
    logic [7:0]        lead_in[$];
    logic [MODE_W-1:0] mode_plan[PHASE_COUNT];
    logic [SEL_W-1:0]  sel_plan[PHASE_COUNT];
    int                idle_plan[4];
    int                stall_plan[4];

    idle_plan  = '{0, 88, 0, 7};
    stall_plan = '{0, 0, 88, 7};
    mode_plan  = '{MODE_BYTE, MODE_TWO_BITS, MODE_FOUR_BITS, MODE_ONE_BIT,
                   MODE_ONE_BIT, MODE_W'($urandom), MODE_ONE_BIT, MODE_BYTE};
    sel_plan   = '{3'd7, 3'd0, 3'd7, 3'd0, 3'd7, SEL_W'($urandom), SEL_W'($urandom), 3'd0};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lead-in: stray bytes, a broken prefix, then another stray byte.
    configure(1'b1, MODE_ONE_BIT, 3'd7);
    payload_len = $urandom_range(1150, 1250);
    seg_len     = 16'(payload_len + 2);
    lead_in     = '{8'h00, MARKER_DQT, MARKER_PREFIX, 8'h00, 8'h7F};
    foreach (lead_in[i]) send_byte(lead_in[i]);

    // Random noise before the marker, with prefixes that are never completed.
    repeat (20) begin
      if ($urandom_range(3) == 0) begin
        send_byte(MARKER_PREFIX);
        send_byte(8'($urandom_range(8'hDA)));
      end else begin
        send_byte(8'($urandom_range(8'hFE)));
      end
    end

    // Marker with a fill byte, the length, the table header and one character.
    lead_in = '{MARKER_PREFIX, MARKER_PREFIX, MARKER_DQT, seg_len[15:8], seg_len[7:0],
                8'hFF, 8'h80, 8'h00, 8'h80, 8'h80, 8'h00, 8'h00, 8'hFF, 8'h7F};
    foreach (lead_in[i]) send_byte(lead_in[i]);

    // Random payload in phases, each with its own settings and idling.
    left  = payload_len - 9;
    chunk = left / PHASE_COUNT;
    for (int k = 0; k < PHASE_COUNT; k++) begin
      wait_drained();
      idle_pct = idle_plan[k % 4];
      stall_pct <= stall_plan[k % 4];
      // One phase changes only bit_select, so a character is left half built.
      configure(k != 4, mode_plan[k], sel_plan[k]);
      n = (k == PHASE_COUNT - 1) ? left : chunk;
      repeat (n) send_byte(payload_byte());
      left = left - n;
    end

    // After the segment every byte is ignored, a new marker too.
    wait_drained();
    configure(1'b1, MODE_BYTE, 3'd7);
    send_byte(MARKER_PREFIX);
    send_byte(MARKER_DQT);
    send_byte(8'h00);
    send_byte(8'h10);
    repeat (26) send_byte(payload_byte());

    stall_pct <= 0;
    wait_drained();
    if (mismatch_count == 0 && chars_in_flight == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/dqt_pkg.sv
rtl/core/dqt_queue.sv
rtl/core/dqt_front.sv
rtl/core/dqt_packer.sv
rtl/core/dqt_lsb_payload_extractor.sv
rtl/core/dqt_checker.sv
bench/dqt_char_checker.sv
bench/dqt_lsb_payload_extractor_tb.sv
